FILE: sv/egs_pkg.sv
// Shared constants and types for the epoch/goodness scheduler.
`timescale 1ns / 1ps

package egs_pkg;

  // Table size and derived index width.
  localparam int NUM_PROCS = 32;
  localparam int IDX_W     = $clog2(NUM_PROCS);

  // Field widths of a table entry.
  localparam int PRIO_W = 8;
  localparam int QUANT_W = 9;
  localparam int GOOD_W = 10;

  // Largest value the quantum counter may hold.
  localparam logic [GOOD_W-1:0] QUANT_MAX = GOOD_W'(511);

  // Request action codes.
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_EPOCH = 2'd1;
  localparam logic [1:0] ACT_PICK  = 2'd2;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EPOCH = 4'b0010,
    S_PICK  = 4'b0100,
    S_FIN   = 4'b1000
  } egs_state_t;

endpackage

FILE: sv/epoch_goodness_scheduler_core.sv
// Epoch/goodness scheduler core: a table of process entries with a sequencer that walks
// it one entry per cycle. A write request loads one entry and returns its all-zero result
// on the next cycle, so writes can follow each other with no gap. A new-epoch request
// refreshes every entry's quantum counter and goodness, and a pick request scans the ready
// entries for the greatest positive goodness (ties go to the higher index). Both walk all
// NUM_PROCS entries, then pass through the finish state, which loads the result register
// and returns the sequencer to idle once that register is free. The single entry-update and
// compare unit visits one table entry per cycle, which sets the length of a scan. Requests
// are taken only while the sequencer is idle and the result register is free or being
// emptied. The table resets to all zero at once.
`timescale 1ns / 1ps

module epoch_goodness_scheduler_core
  import egs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // Request channel.
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [1:0] action,
  input  logic [4:0] proc_index,
  input  logic       in_use,
  input  logic       is_ready,
  input  logic [7:0] priority_req,
  input  logic [8:0] quantum_left,
  input  logic [9:0] goodness_value,
  // Result channel.
  output logic       res_valid,
  input  logic       res_stall,
  output logic [4:0] chosen_process,
  output logic       found,
  output logic       epoch_over
);

  // Process table.
  logic              slot_used      [NUM_PROCS];
  logic              ready_mark     [NUM_PROCS];
  logic [PRIO_W-1:0] prio_store     [NUM_PROCS];
  logic [QUANT_W-1:0] quantum_store [NUM_PROCS];
  logic [GOOD_W-1:0] goodness_store [NUM_PROCS];

  // Sequencer and scan registers.
  egs_state_t        state;
  logic [IDX_W-1:0]  cnt;
  logic              picking;
  logic              have;
  logic [GOOD_W-1:0] best;
  logic [IDX_W-1:0]  best_idx;

  logic              cnt_last;
  logic              res_free;
  logic              req_take;
  logic              res_load;

  // Shared entry unit operands and results.
  logic [PRIO_W-1:0]  cur_prio;
  logic [QUANT_W-1:0] cur_quant;
  logic [GOOD_W-1:0]  cur_good;
  logic [GOOD_W-1:0]  refresh_sum;
  logic [QUANT_W-1:0] quant_next;
  logic [QUANT_W-1:0] quant_eff;
  logic [GOOD_W-1:0]  good_next;
  logic               pick_hit;

  assign cnt_last  = (cnt == IDX_W'(NUM_PROCS - 1));
  assign res_free  = !res_valid || !res_stall;
  assign req_stall = !((state == S_IDLE) && res_free);
  assign req_take  = req_valid && !req_stall;

  // A result is loaded at the end of a scan or right after a write or unused code.
  assign res_load  = ((state == S_FIN) && res_free) ||
                     (req_take && (action != ACT_EPOCH) && (action != ACT_PICK));

  // Entry unit: counter refresh with saturation, goodness, and the pick compare.
  always_comb begin
    cur_prio  = prio_store[cnt];
    cur_quant = quantum_store[cnt];
    cur_good  = goodness_store[cnt];
    if (cur_quant == '0) begin
      refresh_sum = GOOD_W'(cur_prio);
    end else begin
      refresh_sum = GOOD_W'(cur_quant >> 1) + GOOD_W'(cur_prio);
    end
    if (refresh_sum > QUANT_MAX) begin
      quant_next = QUANT_W'(QUANT_MAX);
    end else begin
      quant_next = QUANT_W'(refresh_sum);
    end
    quant_eff = slot_used[cnt] ? quant_next : cur_quant;
    good_next = GOOD_W'(quant_eff) + GOOD_W'(cur_prio);
    pick_hit  = ready_mark[cnt] && (cur_good != '0) && (cur_good >= best);
  end

  // Sequencer, table updates and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      cnt       <= '0;
      picking   <= 1'b0;
      have      <= 1'b0;
      for (int i = 0; i < NUM_PROCS; i++) begin
        slot_used[i]      <= 1'b0;
        ready_mark[i]     <= 1'b0;
        prio_store[i]     <= '0;
        quantum_store[i]  <= '0;
        goodness_store[i] <= '0;
      end
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_take) begin
            cnt      <= '0;
            have     <= 1'b0;
            best     <= '0;
            best_idx <= '0;
            unique case (action)
              ACT_EPOCH: begin
                picking <= 1'b0;
                state   <= S_EPOCH;
              end
              ACT_PICK: begin
                picking <= 1'b1;
                state   <= S_PICK;
              end
              default: begin
                // A write, or an unused code, answers at once with a zero result.
                if (action == ACT_WRITE && int'(proc_index) < NUM_PROCS) begin
                  slot_used[IDX_W'(proc_index)]      <= in_use;
                  ready_mark[IDX_W'(proc_index)]     <= is_ready;
                  prio_store[IDX_W'(proc_index)]     <= priority_req;
                  quantum_store[IDX_W'(proc_index)]  <= quantum_left;
                  goodness_store[IDX_W'(proc_index)] <= goodness_value;
                end
                chosen_process <= '0;
                found          <= 1'b0;
                epoch_over     <= 1'b0;
              end
            endcase
          end
        end
        S_EPOCH: begin
          // Refresh one entry per cycle.
          quantum_store[cnt]  <= quant_eff;
          goodness_store[cnt] <= good_next;
          cnt <= cnt + 1'b1;
          if (cnt_last) begin
            state <= S_FIN;
          end
        end
        S_PICK: begin
          // Keep the best ready entry seen so far; later entries win ties.
          if (pick_hit) begin
            best     <= cur_good;
            best_idx <= cnt;
            have     <= 1'b1;
          end
          cnt <= cnt + 1'b1;
          if (cnt_last) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (res_free) begin
            chosen_process <= have ? 5'(best_idx) : 5'd0;
            found          <= have;
            epoch_over     <= picking && !have;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/egs_checker.sv
// Port-level assertions for the epoch/goodness scheduler, bound to the top level.
`timescale 1ns / 1ps

module egs_checker
  import egs_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_stall,
  input logic [1:0] action,
  input logic       res_valid,
  input logic       res_stall,
  input logic [4:0] chosen_process,
  input logic       found,
  input logic       epoch_over
);

  // A stalled result stays and holds its fields.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(chosen_process) && $stable(found)
      && $stable(epoch_over))
    else $error("result changed while stalled");

  // A result never claims both a choice and the end of the epoch.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(found && epoch_over))
    else $error("found and epoch_over both set");

  // Without a choice the null process is reported.
  a_null_process: assert property (@(posedge clk) disable iff (rst)
    res_valid && !found |-> chosen_process == 5'd0)
    else $error("nonzero process without a choice");

  // A table scan keeps further requests out on the next cycle.
  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && (action == ACT_EPOCH || action == ACT_PICK) |=> req_stall)
    else $error("request taken during a table scan");

endmodule

bind epoch_goodness_scheduler_core egs_checker u_egs_checker (.*);

FILE: tb/sv/tb_epoch_goodness_scheduler_core.sv
// Self-checking testbench for the epoch/goodness scheduler core.
`timescale 1ns / 1ps

module tb_epoch_goodness_scheduler_core;
  import egs_pkg::*;

  // The action code that the block leaves unassigned.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int TOTAL_REQS = 850;
  localparam int IDLE_PCT   = 18;
  // Cycle window in which neither side idles.
  localparam int CALM_FROM  = 5000;
  localparam int CALM_TO    = 9000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [1:0] act;
    logic [4:0] idx;
    logic       used;
    logic       rdy;
    logic [7:0] prio;
    logic [8:0] quant;
    logic [9:0] good;
  } sched_req_t;

  typedef struct packed {
    logic [4:0] proc_id;
    logic       hit;
    logic       over;
  } sched_res_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  logic [1:0] action = ACT_WRITE;
  logic [4:0] proc_index = '0;
  logic       in_use = 1'b0;
  logic       is_ready = 1'b0;
  logic [7:0] priority_req = '0;
  logic [8:0] quantum_left = '0;
  logic [9:0] goodness_value = '0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [4:0] chosen_process;
  logic       found;
  logic       epoch_over;

  epoch_goodness_scheduler_core dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .action(action),
    .proc_index(proc_index),
    .in_use(in_use),
    .is_ready(is_ready),
    .priority_req(priority_req),
    .quantum_left(quantum_left),
    .goodness_value(goodness_value),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .chosen_process(chosen_process),
    .found(found),
    .epoch_over(epoch_over)
  );

  // Shadow copy of the process table.
  logic             tbl_used  [NUM_PROCS];
  logic             tbl_ready [NUM_PROCS];
  logic [PRIO_W-1:0]  tbl_prio  [NUM_PROCS];
  logic [QUANT_W-1:0] tbl_quant [NUM_PROCS];
  logic [GOOD_W-1:0]  tbl_good  [NUM_PROCS];

  sched_req_t pending_reqs[$];
  sched_res_t due_choices[$];
  sched_req_t cur_req;
  int unsigned cycle_cnt = 0;
  int mismatches = 0;
  int n_writes = 0, n_epochs = 0, n_picks = 0, n_hits = 0, n_overs = 0, n_unused = 0;

  // Applies one request to the shadow table and returns the result it causes.
  function automatic sched_res_t run_scheduler(sched_req_t r);
    sched_res_t res;
    int unsigned cnt;
    int unsigned best;
    res = '0;
    case (r.act)
      ACT_WRITE: begin
        n_writes++;
        if (r.idx < NUM_PROCS) begin
          tbl_used[r.idx]  = r.used;
          tbl_ready[r.idx] = r.rdy;
          tbl_prio[r.idx]  = r.prio;
          tbl_quant[r.idx] = r.quant;
          tbl_good[r.idx]  = r.good;
        end
      end
      ACT_EPOCH: begin
        n_epochs++;
        for (int i = 0; i < NUM_PROCS; i++) begin
          cnt = 32'(tbl_quant[i]);
          if (tbl_used[i]) begin
            if (cnt == 0) cnt = 32'(tbl_prio[i]);
            else cnt = cnt / 2 + 32'(tbl_prio[i]);
            if (cnt > 32'(QUANT_MAX)) cnt = 32'(QUANT_MAX);
            tbl_quant[i] = QUANT_W'(cnt);
          end
          tbl_good[i] = GOOD_W'(cnt + 32'(tbl_prio[i]));
        end
      end
      ACT_PICK: begin
        n_picks++;
        best = 0;
        // Later index wins a tie, so the compare is greater-or-equal.
        for (int i = 0; i < NUM_PROCS; i++) begin
          if (tbl_ready[i] && tbl_good[i] != 0 && 32'(tbl_good[i]) >= best) begin
            best = 32'(tbl_good[i]);
            res.proc_id = 5'(i);
            res.hit = 1'b1;
          end
        end
        if (res.hit) begin
          n_hits++;
        end else begin
          res.proc_id = '0;
          res.over = 1'b1;
          n_overs++;
        end
      end
      default: n_unused++;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // Biased toward zero, one and full scale.
  function automatic int unsigned corner_val(int unsigned maxv);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return maxv;
      2: return 1;
      default: return $urandom_range(0, maxv);
    endcase
  endfunction

  // Goodness drawn from a few values so that ties are common.
  function automatic logic [9:0] tie_goodness();
    case ($urandom_range(0, 5))
      0: return 10'd0;
      1: return 10'd1;
      2: return 10'd1023;
      3: return 10'd512;
      default: return 10'($urandom);
    endcase
  endfunction

  function automatic sched_req_t noise_req(logic [1:0] act);
    sched_req_t r;
    r = sched_req_t'(36'({$urandom, $urandom}));
    r.act = act;
    return r;
  endfunction

  task automatic add_req(logic [1:0] act, int idx, bit u, bit rd, int pr, int q, int g);
    sched_req_t r;
    r.act = act;
    r.idx = 5'(idx);
    r.used = u;
    r.rdy = rd;
    r.prio = 8'(pr);
    r.quant = 9'(q);
    r.good = 10'(g);
    pending_reqs.push_back(r);
  endtask

  task automatic add_entry_write(int idx, logic [9:0] g);
    add_req(ACT_WRITE, idx, $urandom_range(0, 3) != 0, $urandom_range(0, 9) < 7,
            int'(corner_val(255)), int'(corner_val(511)), int'(g));
  endtask

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Request driver: holds a request until it is taken, then maybe idles.
  always @(posedge clk) begin
    bit calm;
    calm = cycle_cnt >= CALM_FROM && cycle_cnt < CALM_TO;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) due_choices.push_back(run_scheduler(cur_req));
      if (!req_valid || !req_stall) begin
        if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_req = pending_reqs.pop_front();
          action <= cur_req.act;
          proc_index <= cur_req.idx;
          in_use <= cur_req.used;
          is_ready <= cur_req.rdy;
          priority_req <= cur_req.prio;
          quantum_left <= cur_req.quant;
          goodness_value <= cur_req.good;
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    sched_res_t exp_res;
    bit calm;
    calm = cycle_cnt >= CALM_FROM && cycle_cnt < CALM_TO;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (due_choices.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          exp_res = due_choices.pop_front();
          if (chosen_process !== exp_res.proc_id)
            report_mismatch($sformatf("chosen_process %0d, expected %0d",
                                      chosen_process, exp_res.proc_id));
          if (found !== exp_res.hit)
            report_mismatch($sformatf("found %b, expected %b", found, exp_res.hit));
          if (epoch_over !== exp_res.over)
            report_mismatch($sformatf("epoch_over %b, expected %b", epoch_over, exp_res.over));
        end
      end
      res_stall <= !calm && $urandom_range(0, 99) < IDLE_PCT;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int sel;
    int cnt;
    for (int i = 0; i < NUM_PROCS; i++) begin
      tbl_used[i] = 1'b0;
      tbl_ready[i] = 1'b0;
      tbl_prio[i] = '0;
      tbl_quant[i] = '0;
      tbl_good[i] = '0;
    end

    // Directed: empty table, unused code, ties, free-but-ready slot, epoch refresh.
    add_req(ACT_PICK, 0, 0, 0, 0, 0, 0);
    add_req(ACT_UNUSED, 31, 1, 1, 255, 511, 1023);
    add_req(ACT_PICK, 0, 0, 0, 0, 0, 0);
    add_req(ACT_WRITE, 31, 1, 1, 255, 511, 1023);
    add_req(ACT_WRITE, 0, 1, 1, 0, 0, 0);
    add_req(ACT_PICK, 0, 0, 0, 0, 0, 0);
    add_req(ACT_WRITE, 5, 1, 1, 17, 100, 1023);
    add_req(ACT_PICK, 0, 0, 0, 0, 0, 0);
    add_req(ACT_WRITE, 31, 1, 0, 255, 511, 1023);
    add_req(ACT_WRITE, 7, 0, 1, 3, 40, 1023);
    add_req(ACT_PICK, 0, 0, 0, 0, 0, 0);
    add_req(ACT_WRITE, 3, 1, 1, 200, 0, 1);
    add_req(ACT_EPOCH, 0, 0, 0, 0, 0, 0);
    add_req(ACT_PICK, 0, 0, 0, 0, 0, 0);
    add_req(ACT_EPOCH, 0, 0, 0, 0, 0, 0);
    add_req(ACT_PICK, 0, 0, 0, 0, 0, 0);
    add_req(ACT_WRITE, 3, 1, 1, 0, 0, 0);
    add_req(ACT_WRITE, 5, 1, 0, 17, 100, 84);
    add_req(ACT_WRITE, 7, 0, 0, 3, 40, 43);
    add_req(ACT_PICK, 31, 1, 1, 255, 511, 1023);
    add_req(ACT_WRITE, 30, 1, 1, 255, 1, 1);
    add_req(ACT_PICK, 0, 0, 0, 0, 0, 0);
    add_req(ACT_EPOCH, 31, 1, 1, 255, 511, 1023);
    add_req(ACT_PICK, 0, 0, 0, 0, 0, 0);

    // Random rounds: mostly load-refresh-pick sequences, some table drains and noise.
    while (pending_reqs.size() < TOTAL_REQS) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        for (int i = 0; i < NUM_PROCS; i++)
          add_entry_write(i, $urandom_range(0, 4) == 0 ? 10'($urandom) : 10'd0);
        pending_reqs.push_back(noise_req(ACT_PICK));
        pending_reqs.push_back(noise_req(ACT_EPOCH));
        pending_reqs.push_back(noise_req(ACT_PICK));
      end else if (sel < 18) begin
        cnt = $urandom_range(1, 3);
        repeat (cnt) pending_reqs.push_back(noise_req(2'($urandom_range(0, 3))));
      end else begin
        cnt = $urandom_range(1, 8);
        repeat (cnt) add_entry_write(int'($urandom_range(0, NUM_PROCS - 1)), tie_goodness());
        if ($urandom_range(0, 1)) pending_reqs.push_back(noise_req(ACT_EPOCH));
        cnt = $urandom_range(1, 3);
        repeat (cnt) pending_reqs.push_back(noise_req(ACT_PICK));
      end
    end

    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() > 0 || req_valid) @(posedge clk);
    while (due_choices.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_choices.size() > 0)
      report_mismatch($sformatf("%0d results never arrived", due_choices.size()));

    $display("Run covered %0d entry loads, %0d epoch refreshes and %0d unused codes,",
             n_writes, n_epochs, n_unused);
    $display("and %0d picks: %0d chose a process, %0d hit end of epoch.",
             n_picks, n_hits, n_overs);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
sv/egs_pkg.sv
sv/epoch_goodness_scheduler_core.sv
sv/egs_checker.sv
tb/sv/tb_epoch_goodness_scheduler_core.sv
